[rtl/core/kpnf_pkg.sv]
// Shared types and constants of the keyed pixel neighbourhood fill.
package kpnf_pkg;

   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int ROW_W   = 11;
   localparam int SIZE_W  = 12;
   localparam int CSR_W   = 12;
   localparam int CSR_A_W = 2;
   localparam int MAX_HEIGHT = 2048;

   typedef logic [PIX_W-1:0]  pixel_type;
   typedef logic [CHAN_W-1:0] chan_type;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_KEY_DARK_MAX   = 2'd2,
      CSR_KEY_BRIGHT_MIN = 2'd3
   } csr_index_type;

   typedef struct packed {
      chan_type dark_max;
      chan_type bright_min;
   } key_cfg_type;

   function automatic logic is_key(input pixel_type p, input key_cfg_type k);
      logic r;
      r = (p[7:0] <= k.dark_max) && (p[15:8] >= k.bright_min) &&
          (p[23:16] <= k.dark_max);
      return r;
   endfunction

endpackage

[rtl/core/kpnf_linebuf.sv]
// Line store memory: one word per column holds all buffered rows, with write forwarding.
module kpnf_linebuf import kpnf_pkg::*; #(
   parameter int NL = 4,
   parameter int AW = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  pixel_type          wr_pix,
   output logic [NL*PIX_W-1:0] lines
);

   logic [NL*PIX_W-1:0] mem [2**AW];
   logic [NL*PIX_W-1:0] rd_ff;
   logic [NL*PIX_W-1:0] last_data_ff;
   logic [AW-1:0]       last_addr_ff;
   logic                last_valid_ff;
   logic [NL*PIX_W-1:0] wr_word;

   // The read of the next column may have passed the write of this one.
   assign lines = (last_valid_ff && last_addr_ff == wr_addr) ? last_data_ff : rd_ff;
   assign wr_word = {wr_pix, lines[NL*PIX_W-1:PIX_W]};

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
         last_data_ff <= wr_word;
         last_addr_ff <= wr_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
      end else if (wr_en) begin
         last_valid_ff <= 1'b1;
      end
   end

endmodule

[rtl/core/kpnf_window.sv]
// Window of column sums of non-key pixels plus the centre row, and the window totals.
module kpnf_window import kpnf_pkg::*; #(
   parameter int SPAN  = 5,
   parameter int TS_W  = 13,
   parameter int CNT_W = 5
) (
   input  logic                       clock,
   input  logic                       shift,
   input  logic                       en,
   input  logic [(SPAN-1)*PIX_W-1:0]  lines,
   input  pixel_type                  pix,
   input  key_cfg_type                kcfg,
   output logic [TS_W-1:0]            tot_ff [3],
   output logic [CNT_W-1:0]           num_ff,
   output pixel_type                  cpix_ff,
   output logic                       ckey_ff
);

   localparam int HALF = SPAN / 2;
   localparam int CS_W = $clog2(255 * SPAN + 1);
   localparam int CC_W = $clog2(SPAN + 1);

   logic [CS_W-1:0] colsum_ff [SPAN][3];
   logic [CC_W-1:0] colcnt_ff [SPAN];
   pixel_type       crow_ff [SPAN];
   logic            ckrow_ff [SPAN];
   logic [CS_W-1:0] colsum_in [3];
   logic [CC_W-1:0] colcnt_in;
   pixel_type       column [SPAN];
   logic            colkey [SPAN];
   logic [TS_W-1:0] tot_in [3];
   logic [CNT_W-1:0] num_in;

   always_comb begin
      for (int k = 0; k < SPAN; k++) begin
         column[k] = (k < SPAN - 1) ? lines[k*PIX_W +: PIX_W] : pix;
         colkey[k] = is_key(column[k], kcfg);
      end
      colcnt_in = '0;
      for (int ch = 0; ch < 3; ch++) begin
         colsum_in[ch] = '0;
      end
      for (int k = 0; k < SPAN; k++) begin
         if (!colkey[k]) begin
            colcnt_in = colcnt_in + CC_W'(1);
            for (int ch = 0; ch < 3; ch++) begin
               colsum_in[ch] = colsum_in[ch] + CS_W'(column[k][ch*CHAN_W +: CHAN_W]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         for (int j = 0; j < SPAN - 1; j++) begin
            colsum_ff[j] <= colsum_ff[j+1];
            colcnt_ff[j] <= colcnt_ff[j+1];
            crow_ff[j]   <= crow_ff[j+1];
            ckrow_ff[j]  <= ckrow_ff[j+1];
         end
         colsum_ff[SPAN-1] <= colsum_in;
         colcnt_ff[SPAN-1] <= colcnt_in;
         crow_ff[SPAN-1]   <= column[HALF];
         ckrow_ff[SPAN-1]  <= colkey[HALF];
      end
   end

   always_comb begin
      num_in = '0;
      for (int ch = 0; ch < 3; ch++) begin
         tot_in[ch] = '0;
      end
      for (int j = 0; j < SPAN; j++) begin
         num_in = num_in + CNT_W'(colcnt_ff[j]);
         for (int ch = 0; ch < 3; ch++) begin
            tot_in[ch] = tot_in[ch] + TS_W'(colsum_ff[j][ch]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tot_ff  <= tot_in;
         num_ff  <= num_in;
         cpix_ff <= crow_ff[HALF];
         ckey_ff <= ckrow_ff[HALF];
      end
   end

endmodule

[rtl/core/kpnf_mean.sv]
// Mean of the non-key pixels by reciprocal multiplication, and the fill decision.
module kpnf_mean import kpnf_pkg::*; #(
   parameter int SPAN  = 5,
   parameter int TS_W  = 13,
   parameter int CNT_W = 5,
   parameter int LIMIT = 12
) (
   input  logic             clock,
   input  logic             en,
   input  logic [TS_W-1:0]  tot [3],
   input  logic [CNT_W-1:0] num,
   input  pixel_type        cpix,
   input  logic             ckey,
   output pixel_type        res_pix,
   output logic             res_fill
);

   localparam int AREA  = SPAN * SPAN;
   // Exact floor division for any dividend below 2**TS_W and divisor up to AREA.
   localparam int SH    = TS_W + CNT_W;
   localparam int RW    = SH + 1;
   localparam int PW    = TS_W + RW;

   logic [RW-1:0] recip_tab [AREA+1];
   logic [PW-1:0] prod_ff [3];
   logic          fill_ff;
   pixel_type     cpix_ff;

   for (genvar d = 0; d <= AREA; d++) begin : g_recip
      if (d == 0) begin : g_zero
         assign recip_tab[d] = '0;
      end else begin : g_div
         localparam longint unsigned RC = ((64'd1 << SH) + d - 1) / d;
         assign recip_tab[d] = RW'(RC);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int ch = 0; ch < 3; ch++) begin
            prod_ff[ch] <= PW'(tot[ch]) * PW'(recip_tab[num]);
         end
         fill_ff <= ckey && (num > CNT_W'(LIMIT));
         cpix_ff <= cpix;
      end
   end

   always_comb begin
      res_fill = fill_ff;
      res_pix  = cpix_ff;
      if (fill_ff) begin
         for (int ch = 0; ch < 3; ch++) begin
            res_pix[ch*CHAN_W +: CHAN_W] = prod_ff[ch][SH +: CHAN_W];
         end
      end
   end

endmodule

[rtl/core/keyed_pixel_neighbourhood_fill.sv]
// Keyed pixel neighbourhood fill: top level with position counters and pipeline control.
// A pixel passes the input, column sum, window total, product and output registers.
// Throughput: one pixel per cycle; the whole pipeline stalls only while a result waits.
// The line store is one memory word per column, read at acceptance and written one stage later.
// Synchronous active-high reset clears counters, valid bits and registers to 640x480, 50, 200.
// Border pixels that are never window centres give no result transfer.
module keyed_pixel_neighbourhood_fill import kpnf_pkg::*; #(
   parameter int WINDOW    = 5,
   parameter int MAX_WIDTH = 2048
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [23:0]        req_tdata,   // chan_zero, chan_one, chan_two
   input  logic               req_tuser,   // frame_start
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [47:0]        rsp_tdata,   // centre_row, centre_col, out_zero, out_one,
                                           // out_two, zero pad
   output logic               rsp_tuser,   // was_filled
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata
);

   localparam int HALF  = WINDOW / 2;
   localparam int SPAN  = 2 * HALF + 1;
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int TS_W  = $clog2(255 * SPAN * SPAN + 1);
   localparam int CNT_W = $clog2(SPAN * SPAN + 1);
   localparam int PW_W  = 13;

   logic [SIZE_W-1:0] width_ff, height_ff;
   key_cfg_type       kcfg_ff;
   logic [AW-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PW_W-1:0]   w_eff, h_eff, c_a, c_n, r_a, r_n;
   logic              emit_in, en, accept;

   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic              e1_ff, e2_ff, e3_ff, e4_ff;
   logic [ROW_W-1:0]  cr1_ff, cr2_ff, cr3_ff, cr4_ff;
   logic [ROW_W-1:0]  cc1_ff, cc2_ff, cc3_ff, cc4_ff;
   logic [AW-1:0]     addr1_ff;
   pixel_type         pix1_ff;

   logic [(SPAN-1)*PIX_W-1:0] lines;
   logic [TS_W-1:0]   tot [3];
   logic [CNT_W-1:0]  num;
   pixel_type         cpix, res_pix;
   logic              ckey, res_fill;

   logic              out_valid_ff, out_fill_ff;
   logic [ROW_W-1:0]  out_row_ff, out_col_ff;
   pixel_type         out_pix_ff;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(640);
         height_ff <= SIZE_W'(480);
         kcfg_ff   <= '{dark_max: CHAN_W'(50), bright_min: CHAN_W'(200)};
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_IMAGE_WIDTH:    width_ff           <= csr_wdata;
            CSR_IMAGE_HEIGHT:   height_ff          <= csr_wdata;
            CSR_KEY_DARK_MAX:   kcfg_ff.dark_max   <= csr_wdata[CHAN_W-1:0];
            CSR_KEY_BRIGHT_MIN: kcfg_ff.bright_min <= csr_wdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = PW_W'(1);
      end else if (PW_W'(width_ff) > PW_W'(MAX_WIDTH)) begin
         w_eff = PW_W'(MAX_WIDTH);
      end else begin
         w_eff = PW_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = PW_W'(1);
      end else if (PW_W'(height_ff) > PW_W'(MAX_HEIGHT)) begin
         h_eff = PW_W'(MAX_HEIGHT);
      end else begin
         h_eff = PW_W'(height_ff);
      end

      // A counter left beyond a shrunken size starts the next row.
      c_a = req_tuser ? '0 : PW_W'(col_ff);
      r_a = req_tuser ? '0 : PW_W'(row_ff);
      if (c_a >= w_eff) begin
         c_a = '0;
         r_a = r_a + PW_W'(1);
      end
      if (r_a >= h_eff) begin
         r_a = '0;
      end

      c_n = c_a + PW_W'(1);
      r_n = r_a;
      if (c_n >= w_eff) begin
         c_n = '0;
         r_n = r_a + PW_W'(1);
         if (r_n >= h_eff) begin
            r_n = '0;
         end
      end
      col_in = c_n[AW-1:0];
      row_in = r_n[ROW_W-1:0];

      emit_in = (r_a >= PW_W'(2 * HALF)) && (c_a >= PW_W'(2 * HALF)) &&
                (r_a + PW_W'(2) <= h_eff) && (c_a + PW_W'(2) <= w_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         out_valid_ff <= v4_ff && e4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff    <= emit_in;
         cr1_ff   <= ROW_W'(r_a - PW_W'(HALF));
         cc1_ff   <= ROW_W'(c_a - PW_W'(HALF));
         addr1_ff <= c_a[AW-1:0];
         pix1_ff  <= req_tdata;
         e2_ff  <= e1_ff;
         cr2_ff <= cr1_ff;
         cc2_ff <= cc1_ff;
         e3_ff  <= e2_ff;
         cr3_ff <= cr2_ff;
         cc3_ff <= cc2_ff;
         e4_ff  <= e3_ff;
         cr4_ff <= cr3_ff;
         cc4_ff <= cc3_ff;
         out_row_ff  <= cr4_ff;
         out_col_ff  <= cc4_ff;
         out_pix_ff  <= res_pix;
         out_fill_ff <= res_fill;
      end
   end

   kpnf_linebuf #(
      .NL (SPAN - 1),
      .AW (AW)
   ) u_linebuf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (c_a[AW-1:0]),
      .wr_en   (en && v1_ff),
      .wr_addr (addr1_ff),
      .wr_pix  (pix1_ff),
      .lines   (lines)
   );

   kpnf_window #(
      .SPAN  (SPAN),
      .TS_W  (TS_W),
      .CNT_W (CNT_W)
   ) u_window (
      .clock   (clock),
      .shift   (en && v1_ff),
      .en      (en),
      .lines   (lines),
      .pix     (pix1_ff),
      .kcfg    (kcfg_ff),
      .tot_ff  (tot),
      .num_ff  (num),
      .cpix_ff (cpix),
      .ckey_ff (ckey)
   );

   kpnf_mean #(
      .SPAN  (SPAN),
      .TS_W  (TS_W),
      .CNT_W (CNT_W),
      .LIMIT ((WINDOW * WINDOW) / 2)
   ) u_mean (
      .clock    (clock),
      .en       (en),
      .tot      (tot),
      .num      (num),
      .cpix     (cpix),
      .ckey     (ckey),
      .res_pix  (res_pix),
      .res_fill (res_fill)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_pix_ff, out_col_ff, out_row_ff};
   assign rsp_tuser  = out_fill_ff;

endmodule

[verif/kpnf_checker.sv]
// Checker for the keyed pixel neighbourhood fill: predicts and compares every result transfer.
`timescale 1ns / 100ps
module kpnf_checker import kpnf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [23:0]        req_tdata,
   input  logic               req_tuser,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [47:0]        rsp_tdata,
   input  logic               rsp_tuser,
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata,
   output int                 fail_count,
   output int                 pending_count
);

   localparam int HALF = 2;
   localparam int SPAN = 5;
   localparam int MAXW = 2048;

   typedef struct packed {
      logic [10:0] row;
      logic [10:0] col;
      chan_type    c0;
      chan_type    c1;
      chan_type    c2;
      logic        filled;
   } centre_result_type;

   centre_result_type expected_centres[$];

   logic [11:0] width_reg, height_reg;
   chan_type    dark_max, bright_min;
   pixel_type   rows_mem[SPAN-1][MAXW];
   pixel_type   win[SPAN][SPAN];
   int unsigned row_pos, col_pos;

   function automatic logic keyed(pixel_type p);
      return p[7:0] <= dark_max && p[15:8] >= bright_min && p[23:16] <= dark_max;
   endfunction

   task automatic report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic predict_pixel(pixel_type pix, logic sof);
      int unsigned w, h, r, c, s0, s1, s2, n;
      pixel_type col_px[SPAN];
      pixel_type centre;
      centre_result_type res;
      w = width_reg == 0 ? 1 : (width_reg > MAXW ? MAXW : width_reg);
      h = height_reg == 0 ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
      if (sof) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      for (int k = 0; k < SPAN-1; k++) col_px[k] = rows_mem[k][c];
      col_px[SPAN-1] = pix;
      for (int k = 0; k < SPAN-2; k++) rows_mem[k][c] = rows_mem[k+1][c];
      rows_mem[SPAN-2][c] = pix;
      for (int k = 0; k < SPAN; k++) begin
         for (int j = 0; j < SPAN-1; j++) win[k][j] = win[k][j+1];
         win[k][SPAN-1] = col_px[k];
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
      if (r < 2*HALF || c < 2*HALF || r + 2 > h || c + 2 > w) return;
      centre = win[HALF][HALF];
      res.row = 11'(r - HALF);
      res.col = 11'(c - HALF);
      res.filled = 1'b0;
      {res.c2, res.c1, res.c0} = centre;
      if (keyed(centre)) begin
         s0 = 0; s1 = 0; s2 = 0; n = 0;
         foreach (win[k, j])
            if (!keyed(win[k][j])) begin
               s0 += win[k][j][7:0];
               s1 += win[k][j][15:8];
               s2 += win[k][j][23:16];
               n++;
            end
         if (n > (SPAN*SPAN)/2) begin
            res.c0 = chan_type'(s0 / n);
            res.c1 = chan_type'(s1 / n);
            res.c2 = chan_type'(s2 / n);
            res.filled = 1'b1;
         end
      end
      expected_centres = {expected_centres, res};
   endtask

   always @(posedge clock) begin
      centre_result_type got, want;
      if (reset) begin
         width_reg  <= 12'd640;
         height_reg <= 12'd480;
         dark_max   <= 8'd50;
         bright_min <= 8'd200;
         row_pos = 0;
         col_pos = 0;
         foreach (win[k, j]) win[k][j] = '0;
         fail_count = 0;
      end else begin
         if (csr_we)
            case (csr_index_type'(csr_addr))
               CSR_IMAGE_WIDTH:    width_reg  <= csr_wdata;
               CSR_IMAGE_HEIGHT:   height_reg <= csr_wdata;
               CSR_KEY_DARK_MAX:   dark_max   <= csr_wdata[7:0];
               CSR_KEY_BRIGHT_MIN: bright_min <= csr_wdata[7:0];
               default: ;
            endcase
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[10:0], rsp_tdata[21:11], rsp_tdata[29:22],
                   rsp_tdata[37:30], rsp_tdata[45:38], rsp_tuser};
            if (expected_centres.size() == 0) report("result transfer with none expected");
            else begin
               want = expected_centres.pop_front();
               if (got.row != want.row) report($sformatf("row %0d want %0d", got.row, want.row));
               if (got.col != want.col) report($sformatf("col %0d want %0d", got.col, want.col));
               if (got.c0 != want.c0) report($sformatf("ch0 %0d want %0d", got.c0, want.c0));
               if (got.c1 != want.c1) report($sformatf("ch1 %0d want %0d", got.c1, want.c1));
               if (got.c2 != want.c2) report($sformatf("ch2 %0d want %0d", got.c2, want.c2));
               if (got.filled != want.filled) report("filled flag differs");
            end
         end
         if (req_tvalid && req_tready) predict_pixel(req_tdata, req_tuser);
      end
      pending_count = expected_centres.size();
   end

endmodule

[verif/tb_top.sv]
// Testbench top: drives frames and settings into the fill block and gives the verdict.
`timescale 1ns / 100ps
module tb_top;
   import kpnf_pkg::*;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready, req_tuser = 0;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0, rsp_tuser;
   logic [47:0] rsp_tdata;
   logic csr_we = 0;
   logic [CSR_A_W-1:0] csr_addr = '0;
   logic [CSR_W-1:0] csr_wdata = '0;
   int fail_count, pending_count;
   bit idle_free = 0;
   int hold_off = 0;
   chan_type dark_lim = 50, bright_lim = 200;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   keyed_pixel_neighbourhood_fill u_top (.*);
   kpnf_checker u_chk (.*);

   // Receiver: random stalls, plus one long hold-off so the pipeline backs up.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else
         rsp_tready <= idle_free || $urandom_range(99) >= 25;
   end

   task automatic write_csr(csr_index_type idx, int val);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= CSR_W'(val);
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic pixel_type pick_pixel(int mode);
      pixel_type p;
      p = pixel_type'($urandom);
      // Key pixels are biased in so that fills and unfilled key centres both occur.
      if (mode == 1 || (mode == 2 && $urandom_range(99) < 40)) begin
         p[7:0] = 8'($urandom_range(dark_lim));
         p[23:16] = 8'($urandom_range(dark_lim));
         p[15:8] = 8'($urandom_range(255, bright_lim));
      end
      return p;
   endfunction

   // The valid stays high into the next transfer unless an idle gap is taken.
   task automatic send_pixel(pixel_type p, logic sof);
      req_tvalid <= 1;
      req_tdata <= p;
      req_tuser <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!idle_free && $urandom_range(99) < 25) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < 25) @(posedge clock);
      end
   endtask

   task automatic send_frame(int w, int h, int mode);
      for (int i = 0; i < w * h; i++) send_pixel(pick_pixel(mode), i == 0);
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      req_tvalid <= 0;
      while (pending_count != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic set_sizes(int w, int h, int d, int b);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_KEY_DARK_MAX, d);
      write_csr(CSR_KEY_BRIGHT_MIN, b);
      dark_lim = 8'(d);
      bright_lim = 8'(b);
   endtask

   initial begin
      int n, w, h;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: small frame with all-key, all-plain and extreme channel values.
      set_sizes(6, 4, 50, 200);
      send_pixel(24'hFFFFFF, 1);
      send_pixel(24'h000000, 0);
      send_pixel(24'h00FF00, 0);
      for (int i = 3; i < 24; i++) send_pixel(i % 3 == 0 ? 24'h32C832 : pick_pixel(1), 0);
      drain();
      // Limits at the extremes: everything keyed, then nothing keyed.
      set_sizes(7, 6, 255, 0);
      send_frame(7, 6, 0);
      drain();
      set_sizes(1, 1, 0, 255);
      send_frame(1, 1, 0);
      drain();
      set_sizes(4095, 4095, 0, 255);
      send_frame(5, 1, 0);
      drain();
      set_sizes(0, 0, 0, 255);
      send_frame(2, 1, 0);
      drain();
      // Pressure: long receiver hold-off while a frame streams in.
      set_sizes(8, 8, 50, 200);
      hold_off = 300;
      send_frame(8, 8, 2);
      drain();
      n = 0;
      while (n < 960) begin
         w = $urandom_range(4, 16);
         h = $urandom_range(4, 9);
         // The first random frame is a wide one streamed without any idle cycles.
         if (n == 0 || $urandom_range(9) == 0) begin
            w = $urandom_range(120, 160);
            h = 6;
         end
         if (w * h > 1000 - n) begin
            h = 6;
            w = (1000 - n) / 6;
         end
         idle_free = (n == 0) || ($urandom_range(5) == 0);
         set_sizes(w, h, $urandom_range(255), $urandom_range(255));
         if ($urandom_range(1)) begin
            dark_lim = 50; bright_lim = 200;
            write_csr(CSR_KEY_DARK_MAX, 50);
            write_csr(CSR_KEY_BRIGHT_MIN, 200);
         end
         send_frame(w, h, 2);
         n += w * h;
         drain();
      end
      idle_free = 0;
      drain();
      if (fail_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/kpnf_pkg.sv
rtl/core/kpnf_linebuf.sv
rtl/core/kpnf_window.sv
rtl/core/kpnf_mean.sv
rtl/core/keyed_pixel_neighbourhood_fill.sv
verif/kpnf_checker.sv
verif/tb_top.sv
